// File: hdl/csm_pkg.sv
package csm_pkg;

  // Fixed-point format of all coordinates
  localparam int unsigned FracBits = 14;
  localparam int unsigned FieldW   = 16;
  localparam int unsigned MagW     = FracBits + 1;        // magnitude 0..ONE
  localparam int unsigned ProdW    = 2 * MagW;
  localparam int unsigned RadW     = 2 * MagW;            // radicand r << FracBits
  localparam int unsigned RemW     = MagW + 2;
  localparam int unsigned SqSteps  = RadW / 2;            // one result bit per stage
  localparam int unsigned Lanes    = 3;

  localparam logic [MagW-1:0]   One       = MagW'(1) << FracBits;
  localparam logic [ProdW-1:0]  HalfLsb   = ProdW'(1) << (FracBits - 1);
  localparam logic [30:0]       ThirdMul  = 31'h5555_5556;

  // Valid chain: square, product, third, radicand, sqrt steps, multiply, output
  localparam int unsigned PreStages = 4;
  localparam int unsigned NumStages = PreStages + SqSteps + 2;

endpackage

// File: hdl/csm_isqrt.sv
module csm_isqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [csm_pkg::RadW-1:0]      rad_i,
  output logic [csm_pkg::MagW-1:0]      root_o
);

  logic [csm_pkg::RadW-1:0] v_q    [csm_pkg::SqSteps];
  logic [csm_pkg::RemW-1:0] rem_q  [csm_pkg::SqSteps];
  logic [csm_pkg::MagW-1:0] root_q [csm_pkg::SqSteps];

  for (genvar k = 0; k < csm_pkg::SqSteps; k++) begin : g_step
    logic [csm_pkg::RadW-1:0] v_p;
    logic [csm_pkg::RemW-1:0] rem_p;
    logic [csm_pkg::MagW-1:0] root_p;
    logic [csm_pkg::RemW-1:0] rem_sh, trial, rem_d;
    logic                     ge;

    if (k == 0) begin : g_first
      assign v_p    = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
    end

    // digit recurrence: bring down two radicand bits, try (root << 2) | 1
    assign rem_sh = {rem_p[csm_pkg::RemW-3:0], v_p[csm_pkg::RadW-1 -: 2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = rem_sh >= trial;
    assign rem_d  = ge ? rem_sh - trial : rem_sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]    <= {v_p[csm_pkg::RadW-3:0], 2'b00};
        rem_q[k]  <= rem_d;
        root_q[k] <= {root_p[csm_pkg::MagW-2:0], ge};
      end
    end
  end

  assign root_o = root_q[csm_pkg::SqSteps-1];

endmodule

// File: hdl/cube_to_sphere_point_map.sv
// Maps a point on the unit cube (signed Q1.14, three 16-bit fields) to the unit
// sphere, each coordinate scaled by sqrt(1 - a^2/2 - b^2/2 + a^2*b^2/3). Fully
// pipelined: one point per cycle sustained while the output is not stalled; from
// input transaction to output valid a point passes four arithmetic stages, a
// 15-stage square root that resolves one root bit per stage, a multiply stage
// and the output register. The pipeline advances whenever the output
// register is empty or being taken. Inputs beyond +/-1.0 are clamped in
// magnitude, results saturate to +/-1.0.
module cube_to_sphere_point_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // cube_x [15:0], cube_y [31:16], cube_z [47:32]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // sphere_x [15:0], sphere_y [31:16], sphere_z [47:32]
);

  localparam int unsigned MW = csm_pkg::MagW;
  localparam int unsigned PW = csm_pkg::ProdW;
  localparam int unsigned NS = csm_pkg::NumStages;
  localparam int unsigned SS = csm_pkg::SqSteps;

  logic          en;
  logic [NS-1:0] vld_q;

  assign en              = !vld_q[NS-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid_i};
    end
  end

  // per-lane payload
  logic [MW-1:0] m1_q [csm_pkg::Lanes];
  logic [MW-1:0] sq1_q[csm_pkg::Lanes];
  logic [MW-1:0] m2_q [csm_pkg::Lanes];
  logic [MW-1:0] sq2_q[csm_pkg::Lanes];
  logic [MW-1:0] p2_q [csm_pkg::Lanes];
  logic [MW-1:0] m3_q [csm_pkg::Lanes];
  logic [MW-1:0] sh3_q[csm_pkg::Lanes];   // sa/2 + sb/2
  logic [MW-3:0] p33_q[csm_pkg::Lanes];
  logic [MW-1:0] m4_q [csm_pkg::Lanes];
  logic [csm_pkg::RadW-1:0] rad4_q[csm_pkg::Lanes];
  logic [csm_pkg::Lanes-1:0] n1_q, n2_q, n3_q, n4_q;
  logic [MW-1:0] root [csm_pkg::Lanes];
  logic [PW-1:0] prod_q[csm_pkg::Lanes];
  logic [csm_pkg::Lanes-1:0] nm_q;
  logic [csm_pkg::FieldW-1:0] out_q[csm_pkg::Lanes];

  // sidebands alongside the square root
  logic [MW-1:0]             msq_q [SS][csm_pkg::Lanes];
  logic [csm_pkg::Lanes-1:0] nsq_q [SS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < csm_pkg::Lanes; i++) begin
        logic [csm_pkg::FieldW-1:0] raw, absv;
        logic [MW-1:0]              m;
        logic [PW-1:0]              sqp, pp;
        logic [MW+30:0]             tp;
        logic [MW+1:0]              r;
        raw  = s_axis_tdata_i[i*csm_pkg::FieldW +: csm_pkg::FieldW];
        absv = raw[csm_pkg::FieldW-1] ? (~raw + 16'd1) : raw;
        m    = (absv > csm_pkg::FieldW'(csm_pkg::One)) ? csm_pkg::One : absv[MW-1:0];
        // stage 1: clamp and square
        sqp      = PW'(m) * PW'(m) + csm_pkg::HalfLsb;
        m1_q[i]  <= m;
        n1_q[i]  <= raw[csm_pkg::FieldW-1];
        sq1_q[i] <= sqp[csm_pkg::FracBits +: MW];
        // stage 2: product of the other two squares
        pp       = PW'(sq1_q[(i+1)%3]) * PW'(sq1_q[(i+2)%3]) + csm_pkg::HalfLsb;
        p2_q[i]  <= pp[csm_pkg::FracBits +: MW];
        sq2_q[i] <= sq1_q[i];
        m2_q[i]  <= m1_q[i];
        n2_q[i]  <= n1_q[i];
        // stage 3: divide by three
        tp       = (MW+31)'(p2_q[i]) * (MW+31)'(csm_pkg::ThirdMul);
        p33_q[i] <= tp[MW+29:32];
        sh3_q[i] <= MW'({1'b0, sq2_q[(i+1)%3][MW-1:1]})
                  + MW'({1'b0, sq2_q[(i+2)%3][MW-1:1]});
        m3_q[i]  <= m2_q[i];
        n3_q[i]  <= n2_q[i];
        // stage 4: radicand, clamped at zero
        r = (MW+2)'(csm_pkg::One) - (MW+2)'(sh3_q[i]) + (MW+2)'(p33_q[i]);
        rad4_q[i] <= r[MW+1] ? '0 : {r[MW:0], csm_pkg::FracBits'(0)};
        m4_q[i]   <= m3_q[i];
        n4_q[i]   <= n3_q[i];
        // multiply stage
        prod_q[i] <= PW'(msq_q[SS-1][i]) * PW'(root[i]);
        nm_q[i]   <= nsq_q[SS-1][i];
      end
      msq_q[0] <= m4_q;
      nsq_q[0] <= n4_q;
      for (int k = 1; k < SS; k++) begin
        msq_q[k] <= msq_q[k-1];
        nsq_q[k] <= nsq_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < csm_pkg::Lanes; i++) begin : g_lane
    logic [PW-1:0] rnd;
    logic [MW+1:0] mag;
    logic [MW-1:0] sat;

    csm_isqrt u_isqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (rad4_q[i]),
      .root_o (root[i])
    );

    assign rnd = prod_q[i] + csm_pkg::HalfLsb;
    assign mag = {1'b0, rnd[PW-1:csm_pkg::FracBits]};
    assign sat = (mag > (MW+2)'(csm_pkg::One)) ? csm_pkg::One : mag[MW-1:0];

    always_ff @(posedge clk_i) begin
      if (en) begin
        out_q[i] <= nm_q[i] ? (~csm_pkg::FieldW'(sat) + 16'd1) : csm_pkg::FieldW'(sat);
      end
    end

    assign m_axis_tdata_o[i*csm_pkg::FieldW +: csm_pkg::FieldW] = out_q[i];
  end

  property p_ready;
    @(posedge clk_i) disable iff (!rst_ni)
      s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i);
  endproperty
  a_ready: assert property (p_ready) else $error("ready does not follow output stall");

  property p_range(logic [15:0] v);
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o |-> ($signed(v) <= 16'sd16384 && $signed(v) >= -16'sd16384);
  endproperty
  a_range_x: assert property (p_range(m_axis_tdata_o[15:0]))  else $error("sphere_x range");
  a_range_y: assert property (p_range(m_axis_tdata_o[31:16])) else $error("sphere_y range");
  a_range_z: assert property (p_range(m_axis_tdata_o[47:32])) else $error("sphere_z range");

endmodule
